>>> hdl/btpc_pkg.sv
// Shared types and constants for the barometric compensation core.
`default_nettype none
package btpc_pkg;
    localparam int unsigned RawW = 20;
    localparam logic [63:0] FineOffset = 64'd128000;
    localparam logic [63:0] FullScale = 64'd1048576;
    localparam logic [63:0] DivScale = 64'd3125;
    localparam logic [63:0] RoundHalf = 64'd128;
    localparam logic [63:0] CentiMul = 64'd5;

    localparam logic [1:0] CfgTemp = 2'd0;
    localparam logic [1:0] CfgPressLow = 2'd1;
    localparam logic [1:0] CfgPressHigh = 2'd2;
    localparam logic [1:0] CfgPressLast = 2'd3;

    // Shared ALU operations.
    typedef enum logic [2:0] {
        OP_MUL = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_ASR = 3'd3,
        OP_SHL = 3'd4
    } alu_op_t;

    // Sequencer to divider handshake.
    typedef struct packed {
        logic start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [63:0] quo;
    } div_rsp_t;

    function automatic logic [63:0] sext16(input logic [15:0] v);
        sext16 = {{48{v[15]}}, v};
    endfunction
endpackage
`default_nettype wire

>>> hdl/btpc_alu.sv
// Shared 64-bit arithmetic unit: wrapped multiply, add, subtract, shifts.
`default_nettype none
module btpc_alu
    import btpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire alu_op_t     op,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    input  wire logic [5:0]  sh,
    output logic [63:0]      y
);
    // Multiply cut into three 32x32 partial products over registered steps.
    logic [63:0] pp_ll_reg, pp_lh_reg, pp_hl_reg;
    logic [63:0] mul_y;
    always_ff @(posedge aclk) begin
        pp_ll_reg <= a[31:0] * b[31:0];
        pp_lh_reg <= a[31:0] * b[63:32];
        pp_hl_reg <= a[63:32] * b[31:0];
    end
    assign mul_y = pp_ll_reg + {pp_lh_reg[31:0] + pp_hl_reg[31:0], 32'd0};

    always_comb begin
        case (op)
            OP_MUL:  y = mul_y;
            OP_ADD:  y = a + b;
            OP_SUB:  y = a - b;
            OP_ASR:  y = $unsigned($signed(a) >>> sh);
            OP_SHL:  y = a << sh;
            default: y = a;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/btpc_div.sv
// Radix-2 signed 64-bit divider, truncating toward zero, one bit per cycle.
`default_nettype none
module btpc_div
    import btpc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [63:0] rem_reg, quo_reg, den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, neg_reg, done_reg;
    logic [64:0] trial;
    logic [63:0] rem_sh;

    assign rem_sh = {rem_reg[62:0], quo_reg[63]};
    assign trial = {1'b0, rem_sh} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 7'd64;
                rem_reg <= '0;
                quo_reg <= req.num[63] ? 64'd0 - req.num : req.num;
                den_reg <= req.den[63] ? 64'd0 - req.den : req.den;
                neg_reg <= req.num[63] ^ req.den[63];
            end else if (busy_reg) begin
                // Shift one quotient bit in per cycle.
                if (!trial[64]) begin
                    rem_reg <= trial[63:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
    assign rsp.done = done_reg;
    assign rsp.quo = neg_reg ? 64'd0 - quo_reg : quo_reg;
endmodule
`default_nettype wire

>>> hdl/baro_temp_pressure_compensation_core.sv
// Top level: sequencer around the shared ALU and divider.
// Usage: write coefficients through cfg_we/cfg_addr/cfg_wdata while idle.
// The slave channel takes one beat: tdata = {temp_valid, raw_temp,
// press_valid, raw_press} from bit 0 up. s_tready is high only while idle.
// The beat is then worked through 40 ALU steps (each multiply waits for the
// ALU's registered partial products) and a division, on the one shared ALU
// and the bit-serial divider. A new input beat is not taken until the
// previous one has been worked through. A temperature-only beat runs only
// the temperature steps, a pressure-only beat only the pressure steps.
// One result beat follows each input beat on the master channel:
// tdata = {temp_centi, press_q24_8, div_zero} from bit 0 up.
// The result sits in an output register; the next input beat is taken while
// it waits, but that beat's result waits until the receiver takes the first.
// Reset (aresetn low, synchronous) clears the coefficients, fine
// temperature and held outputs to zero, and empties the output register.
`default_nettype none
module baro_temp_pressure_compensation_core
    import btpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // temp_valid, raw_temp, press_valid, raw_press
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata   // temp_centi, press_q24_8, div_zero
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RUN  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_DONE = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    localparam logic [5:0] LastStep = 6'd39;

    state_t state_reg;
    logic [47:0] tc_reg;
    logic [63:0] pl_reg, ph_reg;
    logic [15:0] p9_reg;
    logic [63:0] fine_reg;
    logic [15:0] temp_reg;
    logic [31:0] press_reg;
    logic        dz_reg;
    logic [19:0] rt_reg, rp_reg;
    logic        tv_reg, pv_reg;
    logic [5:0]  step_reg;
    logic [1:0]  wait_reg;
    logic [63:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic        ov_reg;
    logic [55:0] od_reg;

    alu_op_t     op;
    logic [63:0] a, b, y;
    logic [5:0]  sh;
    logic [2:0]  dst;
    div_req_t    dreq;
    div_rsp_t    drsp;

    btpc_alu u_alu (.aclk(aclk), .op(op), .a(a), .b(b), .sh(sh), .y(y));
    btpc_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {48'd0, tc_reg[15:0]};
    assign t2 = sext16(tc_reg[31:16]);
    assign t3 = sext16(tc_reg[47:32]);
    assign p1 = {48'd0, pl_reg[15:0]};
    assign p2 = sext16(pl_reg[31:16]);
    assign p3 = sext16(pl_reg[47:32]);
    assign p4 = sext16(pl_reg[63:48]);
    assign p5 = sext16(ph_reg[15:0]);
    assign p6 = sext16(ph_reg[31:16]);
    assign p7 = sext16(ph_reg[47:32]);
    assign p8 = sext16(ph_reg[63:48]);
    assign p9 = sext16(p9_reg);

    // Microprogram: dst 0..3 = r0..r3, 4 = fine temp, 7 = none.
    // Steps 0..11 temperature, 12..39 pressure (division between 31 and 32).
    always_comb begin
        op = OP_ADD; a = '0; b = '0; sh = '0; dst = 3'd7;
        case (step_reg)
            6'd0:  begin op = OP_SHL; a = t1; sh = 6'd1; dst = 3'd0; end
            6'd1:  begin op = OP_SUB; a = {47'd0, rt_reg[19:3]}; b = r0_reg; dst = 3'd0; end
            6'd2:  begin op = OP_MUL; a = r0_reg; b = t2; dst = 3'd0; end
            6'd3:  begin op = OP_ASR; a = r0_reg; sh = 6'd11; dst = 3'd0; end
            6'd4:  begin op = OP_SUB; a = {48'd0, rt_reg[19:4]}; b = t1; dst = 3'd1; end
            6'd5:  begin op = OP_MUL; a = r1_reg; b = r1_reg; dst = 3'd1; end
            6'd6:  begin op = OP_ASR; a = r1_reg; sh = 6'd12; dst = 3'd1; end
            6'd7:  begin op = OP_MUL; a = r1_reg; b = t3; dst = 3'd1; end
            6'd8:  begin op = OP_ASR; a = r1_reg; sh = 6'd14; dst = 3'd1; end
            6'd9:  begin op = OP_ADD; a = r0_reg; b = r1_reg; dst = 3'd4; end
            6'd10: begin op = OP_MUL; a = fine_reg; b = CentiMul; dst = 3'd0; end
            6'd11: begin op = OP_ADD; a = r0_reg; b = RoundHalf; dst = 3'd0; end
            // r0 = v1, r1 = v1*v1
            6'd12: begin op = OP_SUB; a = fine_reg; b = FineOffset; dst = 3'd0; end
            6'd13: begin op = OP_MUL; a = r0_reg; b = r0_reg; dst = 3'd1; end
            6'd14: begin op = OP_MUL; a = r1_reg; b = p6; dst = 3'd2; end
            6'd15: begin op = OP_MUL; a = r0_reg; b = p5; dst = 3'd3; end
            6'd16: begin op = OP_SHL; a = r3_reg; sh = 6'd17; dst = 3'd3; end
            6'd17: begin op = OP_ADD; a = r2_reg; b = r3_reg; dst = 3'd2; end
            6'd18: begin op = OP_SHL; a = p4; sh = 6'd35; dst = 3'd3; end
            6'd19: begin op = OP_ADD; a = r2_reg; b = r3_reg; dst = 3'd2; end
            6'd20: begin op = OP_MUL; a = r1_reg; b = p3; dst = 3'd1; end
            6'd21: begin op = OP_ASR; a = r1_reg; sh = 6'd8; dst = 3'd1; end
            6'd22: begin op = OP_MUL; a = r0_reg; b = p2; dst = 3'd3; end
            6'd23: begin op = OP_SHL; a = r3_reg; sh = 6'd12; dst = 3'd3; end
            6'd24: begin op = OP_ADD; a = r1_reg; b = r3_reg; dst = 3'd1; end
            6'd25: begin op = OP_ADD; a = r1_reg; b = 64'd1 << 47; dst = 3'd1; end
            6'd26: begin op = OP_MUL; a = r1_reg; b = p1; dst = 3'd1; end
            6'd27: begin op = OP_ASR; a = r1_reg; sh = 6'd33; dst = 3'd1; end
            6'd28: begin op = OP_SUB; a = FullScale; b = {44'd0, rp_reg}; dst = 3'd0; end
            6'd29: begin op = OP_SHL; a = r0_reg; sh = 6'd31; dst = 3'd0; end
            6'd30: begin op = OP_SUB; a = r0_reg; b = r2_reg; dst = 3'd0; end
            6'd31: begin op = OP_MUL; a = r0_reg; b = DivScale; dst = 3'd0; end
            // after division: r0 = p
            6'd32: begin op = OP_ASR; a = r0_reg; sh = 6'd13; dst = 3'd2; end
            6'd33: begin op = OP_MUL; a = r2_reg; b = r2_reg; dst = 3'd2; end
            6'd34: begin op = OP_MUL; a = r2_reg; b = p9; dst = 3'd2; end
            6'd35: begin op = OP_ASR; a = r2_reg; sh = 6'd25; dst = 3'd2; end
            6'd36: begin op = OP_MUL; a = r0_reg; b = p8; dst = 3'd3; end
            6'd37: begin op = OP_ASR; a = r3_reg; sh = 6'd19; dst = 3'd3; end
            6'd38: begin op = OP_ADD; a = r0_reg; b = r2_reg; dst = 3'd0; end
            6'd39: begin op = OP_ADD; a = r0_reg; b = r3_reg; dst = 3'd0; end
            default: begin op = OP_ADD; dst = 3'd7; end
        endcase
    end

    logic step_ok;
    assign step_ok = (op != OP_MUL) || (wait_reg == 2'd2);

    // Temperature result: asr 8 of the rounded sum from step 11, then clamp.
    logic [63:0] tsh;
    logic [15:0] tclamp;
    assign tsh = $unsigned($signed(y) >>> 8);
    always_comb begin
        if ($signed(tsh) < -64'sd32768)      tclamp = 16'h8000;
        else if ($signed(tsh) > 64'sd32767)  tclamp = 16'h7fff;
        else                                 tclamp = tsh[15:0];
    end

    // Final pressure: asr 8 plus p7<<4 (one add on held operands).
    logic [63:0] pfin;
    logic [31:0] pclamp;
    assign pfin = $unsigned($signed(r0_reg) >>> 8) + (p7 << 4);
    always_comb begin
        if (pfin[63])                 pclamp = '0;
        else if (pfin[62:32] != '0)   pclamp = 32'hffff_ffff;
        else                          pclamp = pfin[31:0];
    end

    // The dividend is the product that step 31 finishes.
    assign dreq.num = y;
    assign dreq.den = r1_reg;
    assign dreq.start = (state_reg == ST_RUN) && step_ok && (step_reg == 6'd31);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tc_reg <= '0; pl_reg <= '0; ph_reg <= '0; p9_reg <= '0;
            fine_reg <= '0; temp_reg <= '0; press_reg <= '0;
            ov_reg <= 1'b0; step_reg <= '0; wait_reg <= '0; dz_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CfgTemp:      tc_reg <= cfg_wdata[47:0];
                    CfgPressLow:  pl_reg <= cfg_wdata;
                    CfgPressHigh: ph_reg <= cfg_wdata;
                    CfgPressLast: p9_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (ov_reg && m_tready && state_reg != ST_OUT) ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    tv_reg <= s_tdata[0];
                    rt_reg <= s_tdata[20:1];
                    pv_reg <= s_tdata[21];
                    rp_reg <= s_tdata[41:22];
                    dz_reg <= 1'b0;
                    wait_reg <= '0;
                    step_reg <= s_tdata[0] ? 6'd0 : 6'd12;
                    state_reg <= (s_tdata[0] || s_tdata[21]) ? ST_RUN : ST_OUT;
                end
                ST_RUN: begin
                    wait_reg <= (op == OP_MUL && !step_ok) ? wait_reg + 2'd1 : 2'd0;
                    if (step_ok) begin
                        case (dst)
                            3'd0: r0_reg <= y;
                            3'd1: r1_reg <= y;
                            3'd2: r2_reg <= y;
                            3'd3: r3_reg <= y;
                            3'd4: fine_reg <= y;
                            default: ;
                        endcase
                        step_reg <= step_reg + 6'd1;
                        // Hold the temperature, then go on to pressure or out.
                        if (step_reg == 6'd11) begin
                            temp_reg <= tclamp;
                            state_reg <= pv_reg ? ST_RUN : ST_OUT;
                        end else if (step_reg == 6'd30 && r1_reg == '0) begin
                            press_reg <= '0;
                            dz_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end else if (step_reg == 6'd31) begin
                            state_reg <= ST_DIV;
                        end else if (step_reg == LastStep) begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DIV: if (drsp.done) begin
                    r0_reg <= drsp.quo;
                    step_reg <= 6'd32;
                    state_reg <= ST_RUN;
                end
                ST_DONE: begin
                    press_reg <= pclamp;
                    state_reg <= ST_OUT;
                end
                ST_OUT: if (!ov_reg || m_tready) begin
                    ov_reg <= 1'b1;
                    od_reg <= {7'd0, dz_reg, press_reg, temp_reg};
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata = od_reg;

    // Divider is only started from the run state with a nonzero divisor.
    a_div_den: assert property (@(posedge aclk) disable iff (!aresetn)
        dreq.start |-> dreq.den != '0) else $error("divide by zero started");
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.done |-> state_reg == ST_DIV) else $error("stray divider result");
    a_one_hot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[48]) |-> m_tdata[47:16] == '0) else $error("dz with pressure");
endmodule
`default_nettype wire

>>> sim/baro_comp_checker.sv
// Checker for the barometric compensation core: predicts each result beat and compares.
module baro_comp_checker
    import btpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          div_zero_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        div_zero;
        logic [31:0] press_q24_8;
        logic [15:0] temp_centi;
    } comp_result_t;

    logic [47:0] t_coef;
    logic [63:0] p_coef_lo;
    logic [63:0] p_coef_hi;
    logic [15:0] p9_coef;
    logic signed [63:0] fine_t;
    logic [15:0] held_t;
    logic [31:0] held_p;
    comp_result_t result_q[$];

    function automatic logic signed [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Work out one beat's result and advance the predictor state.
    task automatic compensate(input logic [47:0] beat);
        logic signed [63:0] t1, t2, t3, a, b, v1, v2, t, p, q;
        logic signed [63:0] pc1, pc2, pc3, pc4, pc5, pc6, pc7, pc8, pc9;
        logic [63:0] ma, mb, mq;
        logic dz;
        comp_result_t r;
        dz = 1'b0;
        if (beat[0]) begin
            t1 = {48'd0, t_coef[15:0]};
            t2 = sx16(t_coef[31:16]);
            t3 = sx16(t_coef[47:32]);
            a = $signed({44'd0, beat[20:1]} >> 3) - (t1 <<< 1);
            b = $signed({44'd0, beat[20:1]} >> 4) - t1;
            v1 = (a * t2) >>> 11;
            v2 = (((b * b) >>> 12) * t3) >>> 14;
            fine_t = v1 + v2;
            t = (fine_t * 64'sd5 + 64'sd128) >>> 8;
            if (t < -64'sd32768) t = -64'sd32768;
            else if (t > 64'sd32767) t = 64'sd32767;
            held_t = t[15:0];
        end
        if (beat[21]) begin
            pc1 = {48'd0, p_coef_lo[15:0]};
            pc2 = sx16(p_coef_lo[31:16]);
            pc3 = sx16(p_coef_lo[47:32]);
            pc4 = sx16(p_coef_lo[63:48]);
            pc5 = sx16(p_coef_hi[15:0]);
            pc6 = sx16(p_coef_hi[31:16]);
            pc7 = sx16(p_coef_hi[47:32]);
            pc8 = sx16(p_coef_hi[63:48]);
            pc9 = sx16(p9_coef);
            v1 = fine_t - 64'sd128000;
            v2 = v1 * v1 * pc6;
            v2 = v2 + ((v1 * pc5) <<< 17);
            v2 = v2 + (pc4 <<< 35);
            v1 = ((v1 * v1 * pc3) >>> 8) + ((v1 * pc2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * pc1) >>> 33;
            if (v1 == 0) begin
                held_p = '0;
                dz = 1'b1;
            end else begin
                p = 64'sd1048576 - $signed({44'd0, beat[41:22]});
                p = ((p <<< 31) - v2) * 64'sd3125;
                // Signed divide, truncating toward zero, on magnitudes.
                ma = p[63] ? -p : p;
                mb = v1[63] ? -v1 : v1;
                mq = ma / mb;
                p = (p[63] != v1[63]) ? -$signed(mq) : $signed(mq);
                q = p >>> 13;
                v1 = (pc9 * q * q) >>> 25;
                v2 = (pc8 * p) >>> 19;
                p = ((p + v1 + v2) >>> 8) + (pc7 <<< 4);
                if (p < 0) held_p = '0;
                else if (p > 64'sd4294967295) held_p = 32'hFFFF_FFFF;
                else held_p = p[31:0];
            end
        end
        r.temp_centi = held_t;
        r.press_q24_8 = held_p;
        r.div_zero = dz;
        result_q.push_back(r);
    endtask

    assign pending = result_q.size();

    always @(posedge aclk) begin
        comp_result_t want, got;
        if (!aresetn) begin
            t_coef <= '0;
            p_coef_lo <= '0;
            p_coef_hi <= '0;
            p9_coef <= '0;
            fine_t = '0;
            held_t = '0;
            held_p = '0;
            result_q.delete();
            fail_count <= 0;
            results_seen <= 0;
            div_zero_seen <= 0;
        end else begin
            // Track register writes.
            if (cfg_we) begin
                case (cfg_addr)
                    CfgTemp: t_coef <= cfg_wdata[47:0];
                    CfgPressLow: p_coef_lo <= cfg_wdata;
                    CfgPressHigh: p_coef_hi <= cfg_wdata;
                    CfgPressLast: p9_coef <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) compensate(s_tdata);
            // Compare each result beat with the oldest prediction.
            if (m_tvalid && m_tready) begin
                got = m_tdata[48:0];
                results_seen <= results_seen + 1;
                if (result_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = result_q.pop_front();
                    if (want.div_zero) div_zero_seen <= div_zero_seen + 1;
                    if (got !== want || m_tdata[55:49] !== '0) begin
                        if (fail_count < 10)
                            $display("mismatch: temp exp %0d got %0d, press exp %h got %h, dz exp %b got %b",
                                $signed(want.temp_centi), $signed(got.temp_centi),
                                want.press_q24_8, got.press_q24_8,
                                want.div_zero, got.div_zero);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> sim/tb.sv
// Testbench top: clock, reset, configuration and stimulus for the compensation core.
module tb
    import btpc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = CfgTemp;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // temp_valid, raw_temp, press_valid, raw_press
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;       // temp_centi, press_q24_8, div_zero
    int fail_count, pending, results_seen, div_zero_seen;
    int idle_cycles;
    int beats_sent;
    bit rx_calm = 1'b0;
    bit rx_hold = 1'b0;
    bit tx_calm = 1'b0;

    always #5 aclk = ~aclk;

    baro_temp_pressure_compensation_core DUT (.*);

    baro_comp_checker u_check (.*);

    // Receiver: random stalls, a long hold-off on request.
    always @(posedge aclk) begin
        m_tready <= !rx_hold && (rx_calm || $urandom_range(99) >= 9);
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else if (pending == 0 && !s_tvalid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drive one register write; the caller drops cfg_we after the last one.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Let all results drain, then give the core time to settle.
    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // Hold one beat on the input until accepted; random gaps before it.
    task automatic send(input bit tv, input logic [19:0] rt, input bit pv, input logic [19:0] rp);
        while (!tx_calm && $urandom_range(99) < 9) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, rp, pv, rt, tv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
        beats_sent++;
        // A beat with a valid reading keeps the core busy, so this costs no rate.
        @(posedge aclk);
    endtask

    task automatic send_rand();
        bit tv, pv;
        tv = $urandom_range(99) < 85;
        pv = $urandom_range(99) < 85;
        send(tv, 20'($urandom_range(20'hFFFFF, 0)), pv, 20'($urandom_range(20'hFFFFF, 0)));
    endtask

    // Coefficients near a real sensor's, with random spread.
    task automatic config_typical();
        write_reg(CfgTemp, {16'($signed(-1000) + $urandom_range(50)),
                            16'(26000 + $urandom_range(2000)),
                            16'(27000 + $urandom_range(2000))});
        write_reg(CfgPressLow, {16'(2800 + $urandom_range(200)),
                                16'($signed(-4096) + $urandom_range(200)),
                                16'($signed(-10700) + $urandom_range(200)),
                                16'(36000 + $urandom_range(2000))});
        write_reg(CfgPressHigh, {16'($signed(-16) + $urandom_range(32)),
                                 16'(15000 + $urandom_range(500)),
                                 16'($signed(-10) + $urandom_range(20)),
                                 16'(100 + $urandom_range(100))});
        write_reg(CfgPressLast, 64'(16'(6000 + $urandom_range(200))));
        cfg_we <= 1'b0;
    endtask

    task automatic config_random();
        write_reg(CfgTemp, {$urandom, $urandom});
        write_reg(CfgPressLow, {$urandom, $urandom});
        write_reg(CfgPressHigh, {$urandom, $urandom});
        write_reg(CfgPressLast, 64'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic config_all(input logic [63:0] v);
        write_reg(CfgTemp, v);
        write_reg(CfgPressLow, v);
        write_reg(CfgPressHigh, v);
        write_reg(CfgPressLast, v);
        cfg_we <= 1'b0;
    endtask

    initial begin
        beats_sent = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset coefficients: pressure divisor is zero.
        send(1'b1, 20'hFFFFF, 1'b1, 20'h00000);
        send(1'b0, 20'h00000, 1'b0, 20'h00000);
        drain();

        // Extremes of the coefficient registers.
        config_all('1);
        send(1'b1, 20'h00000, 1'b1, 20'hFFFFF);
        send(1'b1, 20'hFFFFF, 1'b1, 20'h00000);
        send(1'b1, 20'h80000, 1'b0, 20'h7FFFF);
        drain();
        config_all({4{16'h8000}});
        send(1'b1, 20'hFFFFF, 1'b1, 20'hFFFFF);
        send(1'b1, 20'h00000, 1'b1, 20'h00000);
        send(1'b0, 20'h55555, 1'b1, 20'hAAAAA);
        drain();
        config_all({4{16'h7FFF}});
        send(1'b1, 20'hFFFFF, 1'b1, 20'h00001);
        send(1'b1, 20'h00010, 1'b1, 20'hFFFFF);
        send(1'b0, 20'hAAAAA, 1'b0, 20'h55555);
        drain();

        // Typical sensor: saturations, held values and the usual range.
        config_typical();
        send(1'b1, 20'h7E000, 1'b1, 20'h65000);
        send(1'b0, 20'h00000, 1'b1, 20'h40000);
        send(1'b1, 20'h84000, 1'b0, 20'h00000);
        send(1'b1, 20'h00000, 1'b1, 20'hFFFFF);
        send(1'b1, 20'hFFFFF, 1'b1, 20'h00000);
        send(1'b1, 20'h7E000, 1'b1, 20'h65000);
        drain();

        // Random part in phases with new coefficients between them.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 2) config_random(); else config_typical();
            rx_calm = (ph == 3);
            tx_calm = (ph == 3);
            for (int i = 0; i < 150; i++) begin
                if (ph == 5 && i == 20) begin
                    // Receiver holds off while the sender keeps offering.
                    rx_hold = 1'b1;
                    fork
                        begin repeat (800) @(posedge aclk); rx_hold = 1'b0; end
                    join_none
                end
                if (ph == 6 && i == 75) while (pending != 0) @(posedge aclk);
                if ($urandom_range(99) < 80)
                    send(1'b1, 20'(20'h60000 + $urandom_range(20'h3FFFF)), 1'b1,
                         20'(20'h40000 + $urandom_range(20'h5FFFF)));
                else
                    send_rand();
            end
            drain();
        end

        $display("covered %0d input beats, %0d results, %0d zero-divisor cases",
            beats_sent, results_seen, div_zero_seen);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/btpc_pkg.sv
hdl/btpc_alu.sv
hdl/btpc_div.sv
hdl/baro_temp_pressure_compensation_core.sv
sim/baro_comp_checker.sv
sim/tb.sv
